// ===== rtl/core/pgc_pkg.sv =====
// Shared definitions for the pixel gamma correction block: widths, pipeline depth,
// and the base-2 log distance table that every channel lane reads.
// Depends on nothing; used by pgc_lane and pixel_gamma_correction.
package pgc_pkg;

    localparam int CHANNELS  = 3;
    localparam int CHAN_W    = 8;
    localparam int TDATA_W   = ((CHANNELS * CHAN_W + 7) / 8) * 8;
    localparam int GAMMA_W   = 16;
    localparam int FRAC_BITS = 30;
    localparam int GAMMA_SH  = 12;
    localparam int DIST_W    = FRAC_BITS + 3;
    localparam int NEED_W    = DIST_W + GAMMA_W;
    // One stage forms the product, then one stage per result bit.
    localparam int STAGES    = CHAN_W + 1;
    localparam int TAB_DEPTH = 1 << CHAN_W;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd1862;
    localparam logic [CHAN_W-1:0]  FULL_SCALE  = '1;

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [NEED_W-1:0] need_t;
    typedef dist_t dist_tab_t [TAB_DEPTH];

    // log2(n) in Q3.30 by repeated squaring of the normalized mantissa.
    function automatic dist_t lg_q30(input int unsigned n);
        logic [63:0] m;
        logic [FRAC_BITS-1:0] frac;
        int unsigned e;
        frac = '0;
        e = 0;
        if (n == 0) begin
            return '0;
        end
        for (int i = 0; i < 7; i++) begin
            if ((n >> (i + 1)) != 0) begin
                e = i + 1;
            end
        end
        m = (64'(n) << FRAC_BITS) >> e;
        for (int i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> FRAC_BITS;
            frac = {frac[FRAC_BITS-2:0], 1'b0};
            if (m >= (64'd2 << FRAC_BITS)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {3'(e), frac};
    endfunction

    // Distance of each code from full scale in the log domain; never negative.
    function automatic dist_tab_t build_dist();
        dist_tab_t tab;
        dist_t lfull;
        lfull = lg_q30(TAB_DEPTH - 1);
        for (int n = 0; n < TAB_DEPTH; n++) begin
            tab[n] = lfull - lg_q30(n);
        end
        return tab;
    endfunction

    localparam dist_tab_t DIST_TABLE = build_dist();

endpackage

// ===== rtl/core/pgc_lane.sv =====
// One channel lane of the gamma correction pipeline: product stage followed by
// a bit-per-stage search over the log distance table.
// Depends on pgc_pkg.
module pgc_lane (
    input  logic                                aclk,
    input  logic [pgc_pkg::STAGES-1:0]          stage_en,
    input  logic [pgc_pkg::GAMMA_W-1:0]         gamma,
    input  logic [pgc_pkg::CHAN_W-1:0]          x_in,
    output logic [pgc_pkg::CHAN_W-1:0]          y_out
);

    localparam int LAST = pgc_pkg::STAGES - 1;

    pgc_pkg::need_t             need_reg  [LAST];
    logic                       force_reg [LAST];
    logic                       zero_reg  [LAST];
    logic [pgc_pkg::CHAN_W-1:0] y_reg     [pgc_pkg::STAGES];

    pgc_pkg::need_t need_next;

    // Required log distance: gamma times the distance of the input.
    assign need_next = pgc_pkg::NEED_W'(gamma) *
                       pgc_pkg::NEED_W'(pgc_pkg::DIST_TABLE[x_in]);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            need_reg[0]  <= need_next;
            force_reg[0] <= (gamma == '0);
            zero_reg[0]  <= (x_in == '0);
            y_reg[0]     <= '0;
        end
    end

    for (genvar k = 1; k < pgc_pkg::STAGES; k++) begin : g_search
        logic [pgc_pkg::CHAN_W-1:0] cand;
        logic                       take;
        logic [pgc_pkg::CHAN_W-1:0] y_next;

        assign cand = y_reg[k-1] | (pgc_pkg::CHAN_W'(1) << (pgc_pkg::STAGES - 1 - k));
        assign take = pgc_pkg::NEED_W'({pgc_pkg::DIST_TABLE[cand],
                                        {pgc_pkg::GAMMA_SH{1'b0}}}) >= need_reg[k-1];

        if (k == LAST) begin : g_final
            // A zero exponent wins over a zero input.
            always_comb begin
                if (force_reg[k-1]) begin
                    y_next = pgc_pkg::FULL_SCALE;
                end else if (zero_reg[k-1]) begin
                    y_next = '0;
                end else begin
                    y_next = take ? cand : y_reg[k-1];
                end
            end
        end else begin : g_mid
            assign y_next = take ? cand : y_reg[k-1];

            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    need_reg[k]  <= need_reg[k-1];
                    force_reg[k] <= force_reg[k-1];
                    zero_reg[k]  <= zero_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                y_reg[k] <= y_next;
            end
        end
    end

    assign y_out = y_reg[LAST];

endmodule

// ===== rtl/core/pixel_gamma_correction.sv =====
// Top level of the pixel gamma correction block: stream handshake, stage control,
// exponent register and the per-channel lanes. Depends on pgc_pkg and pgc_lane.
//
// Usage:
//   One pixel enters per item on the s_ channel; s_tdata carries the channels
//   from the lowest bit up. Each channel x is replaced by floor(255*(x/255)^g),
//   g = gamma_q4_12 / 4096, and the corrected pixel leaves on the m_ channel in
//   the same packing. Every accepted item gives exactly one result item.
//   The exponent is loaded through cfg_wr_en / cfg_wr_data and should only be
//   changed while no items are in flight.
//   One stage forms the product of the exponent and the input's log distance,
//   then one stage per output bit resolves the result against the constant log
//   table. Throughput is one item per cycle while m_tready is high; the channels
//   run in parallel lanes so width does not cost rate.
//   Reset (aresetn low at a clock edge) empties all stages and loads the
//   exponent with 1862, about 1/2.2.
//   When the receiver stalls, each stage holds its item only if the next one is
//   occupied, so bubbles close up and the input keeps accepting until all nine
//   stages are full; s_tready is high whenever the output register is empty.
module pixel_gamma_correction (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pgc_pkg::GAMMA_W-1:0]   cfg_wr_data,    // gamma_q4_12
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pgc_pkg::TDATA_W-1:0]   s_tdata,        // chan_a_in, chan_b_in, chan_c_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pgc_pkg::TDATA_W-1:0]   m_tdata         // chan_a_out, chan_b_out, chan_c_out
);

    localparam int ST = pgc_pkg::STAGES;

    logic [pgc_pkg::GAMMA_W-1:0] gamma_reg;
    logic [pgc_pkg::GAMMA_W-1:0] gamma_next;
    logic [ST-1:0]               valid_reg;
    logic [ST-1:0]               valid_next;
    logic [ST-1:0]               valid_in;
    logic [ST:0]                 stage_rdy;

    // Exponent register.
    always_comb begin
        gamma_next = cfg_wr_en ? cfg_wr_data : gamma_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= pgc_pkg::GAMMA_RESET;
        end else begin
            gamma_reg <= gamma_next;
        end
    end

    // A stage can take a new item when it is empty or its item moves on.
    assign stage_rdy[ST] = m_tready;
    assign valid_in      = {valid_reg[ST-2:0], s_tvalid};

    for (genvar i = 0; i < ST; i++) begin : g_ctl
        assign stage_rdy[i]  = !valid_reg[i] || stage_rdy[i+1];
        assign valid_next[i] = stage_rdy[i] ? valid_in[i] : valid_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[ST-1];

    // Lanes, one per color channel; their output registers merge into m_tdata.
    for (genvar c = 0; c < pgc_pkg::CHANNELS; c++) begin : g_lane
        pgc_lane u_lane (
            .aclk     (aclk),
            .stage_en (stage_rdy[ST-1:0]),
            .gamma    (gamma_reg),
            .x_in     (s_tdata[c*pgc_pkg::CHAN_W +: pgc_pkg::CHAN_W]),
            .y_out    (m_tdata[c*pgc_pkg::CHAN_W +: pgc_pkg::CHAN_W])
        );
    end

    if (pgc_pkg::TDATA_W > pgc_pkg::CHANNELS * pgc_pkg::CHAN_W) begin : g_pad
        assign m_tdata[pgc_pkg::TDATA_W-1:pgc_pkg::CHANNELS*pgc_pkg::CHAN_W] = '0;
    end

    // An empty output register never blocks the input.
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // A full, stalled pipeline refuses new items.
    a_full_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg && !m_tready) |-> !s_tready)
        else $error("item accepted into a full stalled pipeline");

    // A held stage keeps its item.
    for (genvar i = 0; i < ST; i++) begin : g_hold_chk
        a_stage_hold : assert property (@(posedge aclk) disable iff (!aresetn)
            (valid_reg[i] && !stage_rdy[i]) |=> valid_reg[i])
            else $error("held stage lost its item");
    end

    // An item entering an empty pipeline reaches the output after the full depth.
    a_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (valid_reg == '0)) |-> ##(pgc_pkg::STAGES) m_tvalid)
        else $error("item did not arrive at the output in time");

endmodule

// ===== sim/tb_pixel_gamma_correction.sv =====
// Self-checking testbench for pixel_gamma_correction: streams pixels under random
// source gaps and sink stalls, predicts each corrected pixel in fixed point, and
// compares every channel of every result. Depends on pgc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_pixel_gamma_correction;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_LEN   = 12;
    // Cycles without any handshake on either side before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 110;

    // Channel a sits in the low byte, matching the tdata packing.
    typedef struct packed {
        logic [7:0] c;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [pgc_pkg::GAMMA_W-1:0]  cfg_wr_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [pgc_pkg::TDATA_W-1:0]  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [pgc_pkg::TDATA_W-1:0]  m_tdata;

    pixel_gamma_correction dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Shadow of the exponent register as the block should hold it.
    logic [pgc_pkg::GAMMA_W-1:0] gamma_shadow;
    // Distance of each code from full scale in the log2 domain, Q3.30.
    logic [32:0]        log_gap [256];
    pixel_t             corrected_q [$];
    int                 pixels_pending;
    int                 mismatch_count;
    int                 quiet_cycles;
    int                 rx_hold_cycles;
    bit                 tx_gaps_on;
    bit                 rx_stalls_on;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // log2(n) in Q3.30: integer part from the leading one, fraction bits from
    // squaring the normalized mantissa thirty times with truncation.
    function automatic logic [32:0] log2_fixed(input int unsigned n);
        logic [63:0]  mant;
        logic [29:0]  frac;
        int unsigned  msb;
        frac = '0;
        msb  = 0;
        if (n == 0) begin
            return '0;
        end
        while (msb < 7 && (n >> (msb + 1)) != 0) begin
            msb++;
        end
        mant = (64'(n) << 30) >> msb;
        for (int i = 0; i < 30; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                mant  = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        return {msb[2:0], frac};
    endfunction

    // Largest y whose log distance, scaled by 4096, still covers gamma times the
    // input's distance. A zero exponent maps everything, black included, to white.
    function automatic logic [7:0] gamma_level(input logic [7:0] x,
                                               input logic [pgc_pkg::GAMMA_W-1:0] g);
        logic [63:0] need;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (g == 0) begin
            return 8'd255;
        end
        if (x == 0) begin
            return 8'd0;
        end
        need = 64'(g) * 64'(log_gap[x]);
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (64'd4096 * 64'(log_gap[mid]) >= need) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo[7:0];
    endfunction

    function automatic pixel_t gamma_pixel(input pixel_t px,
                                           input logic [pgc_pkg::GAMMA_W-1:0] g);
        pixel_t res;
        res.a = gamma_level(px.a, g);
        res.b = gamma_level(px.b, g);
        res.c = gamma_level(px.c, g);
        return res;
    endfunction

    // Random level biased toward black, white and the codes just above black and just below white.
    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 4));
            3: return 8'($urandom_range(250, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.a = rand_level();
        px.b = rand_level();
        px.c = rand_level();
        return px;
    endfunction

    // Offers one item, optionally after a gap, and records the corrected pixel
    // once the block takes it. Returns at the accepting clock edge.
    task automatic send_pixel(input pixel_t px);
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        corrected_q.push_back(gamma_pixel(px, gamma_shadow));
        pixels_pending++;
    endtask

    task automatic send_pixel3(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        pixel_t px;
        px.a = a;
        px.b = b;
        px.c = c;
        send_pixel(px);
    endtask

    // The exponent may only change with the pipeline empty; every item gives a
    // result, so an empty expectation queue means nothing is in flight.
    task automatic write_gamma(input logic [pgc_pkg::GAMMA_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pixels_pending == 0);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gamma_shadow = value;
    endtask

    // Runs with the exponent left at its reset value of about 1/2.2.
    task automatic test_reset_exponent();
        send_pixel3(8'd0, 8'd255, 8'd1);
        send_pixel3(8'd128, 8'd254, 8'd2);
        send_pixel3(8'h55, 8'hAA, 8'h0F);
        send_pixel3(8'hF0, 8'h01, 8'h80);
    endtask

    // With an exponent of exactly one the block must pass pixels through.
    task automatic test_unit_exponent();
        write_gamma(16'd4096);
        send_pixel3(8'd0, 8'd1, 8'd255);
        send_pixel3(8'd127, 8'd128, 8'd254);
        send_pixel3(8'h55, 8'hAA, 8'h3C);
    endtask

    // Zero exponent: every channel saturates, including black.
    task automatic test_zero_exponent();
        write_gamma(16'd0);
        send_pixel3(8'd0, 8'd0, 8'd0);
        send_pixel3(8'd1, 8'd128, 8'd255);
    endtask

    // Largest exponent: dark codes truncate to zero, full scale stays.
    task automatic test_max_exponent();
        write_gamma(16'hFFFF);
        send_pixel3(8'd254, 8'd255, 8'd0);
        send_pixel3(8'd253, 8'd250, 8'd1);
    endtask

    // Smallest nonzero exponent: results crowd toward white, but black must still
    // give zero. Then an exponent of eight is checked on bright codes.
    task automatic test_min_exponent();
        write_gamma(16'd1);
        send_pixel3(8'd0, 8'd1, 8'd2);
        send_pixel3(8'd128, 8'd254, 8'd255);
        write_gamma(16'h8000);
        send_pixel3(8'd254, 8'd200, 8'd255);
    endtask

    // The sink holds off long enough that every stage fills and s_tready drops
    // while the source keeps offering items back to back.
    task automatic test_backpressure();
        write_gamma(16'd1862);
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (40) send_pixel(rand_pixel());
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_exponents();
        logic [pgc_pkg::GAMMA_W-1:0] g;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: g = 16'd1862;
                1: g = 16'hFFFF;
                2: g = 16'd1;
                3: g = 16'd4096;
                4: g = 16'd0;
                5: g = 16'($urandom_range(1, 8191));
                6: g = 16'($urandom_range(2048, 12288));
                default: g = 16'($urandom_range(0, 65535));
            endcase
            write_gamma(g);
            // Some phases run flat out; the last ones have no idling at all.
            tx_gaps_on   = (phase < 8) && (phase != 3);
            rx_stalls_on = (phase < 8) && (phase != 5);
            repeat (PHASE_ITEMS) send_pixel(rand_pixel());
        end
    endtask

    // Sink side: a requested long hold is counted out here; otherwise random
    // stall bursts while enabled.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                while (rx_hold_cycles > 0) begin
                    @(posedge aclk);
                    rx_hold_cycles--;
                end
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (corrected_q.size() == 0) begin
                $error("result item with no pending expectation: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = corrected_q.pop_front();
                pixels_pending--;
                if (got.a !== want.a) begin
                    $error("chan_a_out mismatch: expected %0d, actual %0d", want.a, got.a);
                    mismatch_count++;
                end
                if (got.b !== want.b) begin
                    $error("chan_b_out mismatch: expected %0d, actual %0d", want.b, got.b);
                    mismatch_count++;
                end
                if (got.c !== want.c) begin
                    $error("chan_c_out mismatch: expected %0d, actual %0d", want.c, got.c);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        gamma_shadow   = pgc_pkg::GAMMA_RESET;
        pixels_pending = 0;
        mismatch_count = 0;
        rx_hold_cycles = 0;
        tx_gaps_on     = 1'b1;
        rx_stalls_on   = 1'b1;
        for (int n = 0; n < 256; n++) begin
            log_gap[n] = log2_fixed(255) - log2_fixed(n);
        end

        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_exponent();
        test_unit_exponent();
        test_zero_exponent();
        test_max_exponent();
        test_min_exponent();
        test_backpressure();
        test_random_exponents();

        // Drain: wait for every expected pixel, then keep running to catch any
        // spurious trailing result.
        s_tvalid <= 1'b0;
        wait (pixels_pending == 0);
        repeat (3 * pgc_pkg::STAGES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
